// ===== design/cslp_pkg.sv =====
// ----------------------------------------------------------------------------
// cslp_pkg
// Shared types, widths and helpers for the clip space line projector.
// ----------------------------------------------------------------------------
`default_nettype none

package cslp_pkg;

    // Clip coordinates stay below 2^46 in magnitude
    localparam int CLIP_W    = 47;
    // Plane distances and coordinate differences
    localparam int DIST_W    = 48;
    localparam int NUM_PLANES = 6;
    // Configuration register index width (eight matrix registers)
    localparam int CFG_IDX_W = 3;
    // Restoring divider: quotient bits resolved per pipeline stage
    localparam int DIV_STEPS = 4;

    typedef logic signed [CLIP_W-1:0] t_clip;

    // Clip planes, in the order they are applied
    typedef enum logic [2:0] {
        PL_X_LO,    // x + w >= 0
        PL_X_HI,    // w - x >= 0
        PL_Y_LO,    // y + w >= 0
        PL_Y_HI,    // w - y >= 0
        PL_Z_LO,    // z >= 0
        PL_Z_HI     // w - z >= 0
    } t_plane;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [31:0] end_z;
        logic        [31:0] line_color;
    } t_in_item;

    typedef struct packed {
        logic        visible;
        logic [16:0] screen_start_x;
        logic [16:0] screen_start_y;
        logic [16:0] screen_end_x;
        logic [16:0] screen_end_y;
        logic [31:0] out_color;
    } t_out_item;

    // Segment in clip space as it travels through the plane stages
    typedef struct packed {
        logic             ok;
        t_clip [3:0]      a;
        t_clip [3:0]      b;
        logic [31:0]      color;
    } t_seg;

    // One restoring division step: returns {quotient bit, new remainder}.
    // The caller must keep the remainder below the divisor on entry; the function does not enforce it.
    function automatic logic [32:0] div_step(
        input logic [31:0] rem,
        input logic        nb,
        input logic [31:0] d
    );
        logic [32:0] t;
        logic [32:0] dif;
        t   = {rem, nb};
        dif = t - {1'b0, d};
        if (!dif[32]) begin
            div_step = {1'b1, dif[31:0]};
        end else begin
            div_step = {1'b0, t[31:0]};
        end
    endfunction

endpackage

`default_nettype wire

// ===== design/cslp_clip_plane.sv =====
// ----------------------------------------------------------------------------
// cslp_clip_plane
// Pipelined clip of one segment against one homogeneous clip plane.
// ----------------------------------------------------------------------------
`default_nettype none

module cslp_clip_plane #(
    parameter cslp_pkg::t_plane PLANE = cslp_pkg::PL_X_LO
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_vld,
    input  cslp_pkg::t_seg i_seg,
    output logic           o_vld,
    output cslp_pkg::t_seg o_seg
);
    import cslp_pkg::*;

    // Q0.32 ratio plus the integer bit
    localparam int QB  = 33;
    localparam int NST = (QB + DIV_STEPS - 1) / DIV_STEPS;
    localparam int LAT = NST + 6;

    typedef struct packed {
        t_seg                   seg;
        logic                   clip;
        logic                   sel_a;
        logic [3:0][DIST_W-1:0] dmag;
        logic [3:0]             dneg;
    } t_carry;

    typedef struct packed {
        logic [31:0]   rem;
        logic [QB-1:0] q;
        logic [QB-1:0] feed;
        logic [31:0]   d;
    } t_div;

    // Signed distance of a point to this plane
    function automatic logic signed [DIST_W-1:0] plane_dist(input t_clip [3:0] v);
        logic signed [DIST_W-1:0] x;
        logic signed [DIST_W-1:0] y;
        logic signed [DIST_W-1:0] z;
        logic signed [DIST_W-1:0] w;
        x = DIST_W'($signed(v[0]));
        y = DIST_W'($signed(v[1]));
        z = DIST_W'($signed(v[2]));
        w = DIST_W'($signed(v[3]));
        case (PLANE)
            PL_X_LO: plane_dist = x + w;
            PL_X_HI: plane_dist = w - x;
            PL_Y_LO: plane_dist = y + w;
            PL_Y_HI: plane_dist = w - y;
            PL_Z_LO: plane_dist = z;
            PL_Z_HI: plane_dist = w - z;
            default: plane_dist = w - z;
        endcase
    endfunction

    logic [LAT-1:0] r_vld;

    t_seg                     r_s1_seg;
    logic signed [DIST_W-1:0] r_s1_da;
    logic signed [DIST_W-1:0] r_s1_db;

    t_seg                     r_s2_seg;
    logic                     r_s2_clip;
    logic                     r_s2_sel_a;
    logic [DIST_W-1:0]        r_s2_un;
    logic [DIST_W-1:0]        r_s2_ud;
    logic [3:0][DIST_W-1:0]   r_s2_d;
    t_seg                     n_s2_seg;
    logic                     n_s2_clip;
    logic                     n_s2_sel_a;
    logic [DIST_W-1:0]        n_s2_un;
    logic [DIST_W-1:0]        n_s2_ud;
    logic [3:0][DIST_W-1:0]   n_s2_d;

    t_div                     r_dv [NST+1];
    t_carry                   r_dc [NST+1];
    t_div                     n_dv0;
    t_div                     n_dv [1:NST];
    t_carry                   n_dc0;

    logic [3:0][48:0]         r_m1_hi;
    logic [3:0][64:0]         r_m1_lo;
    t_carry                   r_m1_c;
    logic [3:0][48:0]         r_m2_mag;
    t_carry                   r_m2_c;
    t_seg                     r_s6_seg;
    t_seg                     n_s6_seg;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[LAT-2:0], i_vld};
        end
    end

    // Stage 2: classify ends, distances for the ratio, end-to-end deltas
    always_comb begin
        logic                     out_a;
        logic                     out_b;
        logic signed [DIST_W:0]   diff;
        out_a      = r_s1_da[DIST_W-1];
        out_b      = r_s1_db[DIST_W-1];
        n_s2_seg   = r_s1_seg;
        n_s2_seg.ok = r_s1_seg.ok & ~(out_a & out_b);
        n_s2_clip  = r_s1_seg.ok & (out_a ^ out_b);
        n_s2_sel_a = out_a;
        n_s2_un    = out_a ? DIST_W'(-r_s1_da) : DIST_W'(r_s1_da);
        diff       = (DIST_W+1)'(r_s1_da) - (DIST_W+1)'(r_s1_db);
        n_s2_ud    = diff[DIST_W] ? DIST_W'(-diff) : DIST_W'(diff);
        for (int i = 0; i < 4; i++) begin
            n_s2_d[i] = DIST_W'($signed(r_s1_seg.b[i]))
                      - DIST_W'($signed(r_s1_seg.a[i]));
        end
    end

    // Stage 3: scale both ratio operands so the divisor fits in 32 bits
    always_comb begin
        logic [4:0]        sh;
        logic [DIST_W-1:0] un_s;
        logic [DIST_W-1:0] ud_s;
        sh = '0;
        for (int j = 0; j < DIST_W - 32; j++) begin
            if (r_s2_ud[32+j]) begin
                sh = 5'(j + 1);
            end
        end
        un_s          = r_s2_un >> sh;
        ud_s          = r_s2_ud >> sh;
        n_dv0.rem     = {1'b0, un_s[31:1]};
        n_dv0.feed    = {un_s[0], {(QB-1){1'b0}}};
        n_dv0.q       = '0;
        n_dv0.d       = ud_s[31:0];
        n_dc0.seg     = r_s2_seg;
        n_dc0.clip    = r_s2_clip;
        n_dc0.sel_a   = r_s2_sel_a;
        for (int i = 0; i < 4; i++) begin
            n_dc0.dneg[i] = r_s2_d[i][DIST_W-1];
            n_dc0.dmag[i] = r_s2_d[i][DIST_W-1] ? DIST_W'(-$signed(r_s2_d[i]))
                                                 : r_s2_d[i];
        end
    end

    // Divider stages: a few quotient bits per stage
    always_comb begin
        logic [32:0] st;
        for (int s = 0; s < NST; s++) begin
            n_dv[s+1] = r_dv[s];
            for (int j = 0; j < DIV_STEPS; j++) begin
                if (s * DIV_STEPS + j < QB) begin
                    st = div_step(n_dv[s+1].rem, n_dv[s+1].feed[QB-1], n_dv[s+1].d);
                    n_dv[s+1].rem  = st[31:0];
                    n_dv[s+1].q    = {n_dv[s+1].q[QB-2:0], st[32]};
                    n_dv[s+1].feed = {n_dv[s+1].feed[QB-2:0], 1'b0};
                end
            end
        end
    end

    // Final stage: move the outside end to the intersection
    always_comb begin
        logic signed [50:0] av;
        logic signed [50:0] mv;
        logic signed [50:0] p;
        n_s6_seg = r_m2_c.seg;
        for (int i = 0; i < 4; i++) begin
            av = 51'($signed(r_m2_c.seg.a[i]));
            mv = $signed({2'b00, r_m2_mag[i]});
            p  = r_m2_c.dneg[i] ? av - mv : av + mv;
            if (r_m2_c.clip) begin
                if (r_m2_c.sel_a) begin
                    n_s6_seg.a[i] = p[CLIP_W-1:0];
                end else begin
                    n_s6_seg.b[i] = p[CLIP_W-1:0];
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s1_seg   <= i_seg;
            r_s1_da    <= plane_dist(i_seg.a);
            r_s1_db    <= plane_dist(i_seg.b);
            r_s2_seg   <= n_s2_seg;
            r_s2_clip  <= n_s2_clip;
            r_s2_sel_a <= n_s2_sel_a;
            r_s2_un    <= n_s2_un;
            r_s2_ud    <= n_s2_ud;
            r_s2_d     <= n_s2_d;
            r_dv[0]    <= n_dv0;
            r_dc[0]    <= n_dc0;
            for (int s = 0; s < NST; s++) begin
                r_dv[s+1] <= n_dv[s+1];
                r_dc[s+1] <= r_dc[s];
            end
            // delta times ratio, split into high and low partial products
            for (int i = 0; i < 4; i++) begin
                r_m1_hi[i]  <= 49'(r_dc[NST].dmag[i][DIST_W-1:32]) * 49'(r_dv[NST].q);
                r_m1_lo[i]  <= 65'(r_dc[NST].dmag[i][31:0]) * 65'(r_dv[NST].q);
                r_m2_mag[i] <= r_m1_hi[i] + 49'(r_m1_lo[i][64:32]);
            end
            r_m1_c   <= r_dc[NST];
            r_m2_c   <= r_m1_c;
            r_s6_seg <= n_s6_seg;
        end
    end

    assign o_vld = r_vld[LAT-1];
    assign o_seg = r_s6_seg;

endmodule

`default_nettype wire

// ===== design/clip_space_line_projector.sv =====
// ----------------------------------------------------------------------------
// clip_space_line_projector
// Transforms a 3D segment by a 4x4 matrix, clips it in homogeneous space
// and maps the surviving ends to [0,1] viewport coordinates.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (i_in_valid/o_in_ready, i_in_data) takes one segment and
//    its color per transfer; output channel (o_out_valid/i_out_ready,
//    o_out_data) returns exactly one result per segment, in order.
//  - Configuration channel (i_cfg_valid/o_cfg_ready) writes one 64-bit
//    matrix register, two Q16.16 coefficients, per transfer. Always ready.
//    Write only while the pipeline is empty.
//  - Throughput: one segment per cycle while the receiver does not stall.
//    The pipeline has three transform stages, fifteen per clip plane
//    (mostly the Q0.32 ratio divider at four bits per stage), four setup
//    stages plus the viewport divider and the output register.
//  - Reset clears the matrix to zero and empties the pipeline.
//  - When a result waits in the output register and the receiver stalls,
//    the whole pipeline holds and o_in_ready drops; otherwise it advances.
//  - Overflow or a rejected segment gives visible = 0 with all fields zero.
// ----------------------------------------------------------------------------
`default_nettype none

module clip_space_line_projector #(
    parameter int COORD_FRAC_BITS  = 16,
    parameter int SCREEN_FRAC_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  cslp_pkg::t_in_item               i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output cslp_pkg::t_out_item              o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [cslp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [63:0]                      i_cfg_data
);
    import cslp_pkg::*;

    localparam int QS  = SCREEN_FRAC_BITS + 1;
    localparam int NSD = (QS + DIV_STEPS - 1) / DIV_STEPS;
    localparam int NW  = 33 + SCREEN_FRAC_BITS;
    localparam int NSV = NSD + 5;
    localparam logic signed [65:0] CLIP_LIM = 66'sh4000_0000_0000;

    typedef struct packed {
        logic [3:0][31:0] rem;
        logic [3:0][QS-1:0] q;
        logic [3:0][QS-1:0] feed;
        logic [1:0][31:0] d;
        logic             ok;
        logic [31:0]      color;
    } t_sdiv;

    logic               w_adv;
    logic signed [31:0] r_mat [4][4];

    logic [2:0]         r_t_vld;
    logic signed [31:0] w_pt [2][3];
    logic signed [63:0] r_prod [2][4][3];
    logic [31:0]        r_t1_color;
    logic signed [64:0] r_ps0 [2][4];
    logic signed [64:0] r_ps1 [2][4];
    logic [31:0]        r_t2_color;
    t_seg               r_t3_seg;
    t_seg               n_t3_seg;

    logic               w_pl_vld [NUM_PLANES+1];
    t_seg               w_pl_seg [NUM_PLANES+1];

    logic [NSV-1:0]           r_sv;
    logic signed [DIST_W-1:0] r_s1_num [4];
    logic signed [DIST_W-1:0] r_s1_den [2];
    logic                     r_s1_ok;
    logic [31:0]              r_s1_color;
    logic signed [DIST_W-1:0] n_s1_num [4];
    logic signed [DIST_W-1:0] n_s1_den [2];
    logic                     n_s1_ok;
    logic [DIST_W-1:0]        r_s2_un [4];
    logic [DIST_W-1:0]        r_s2_ud [2];
    logic                     r_s2_ok;
    logic [31:0]              r_s2_color;
    logic [31:0]              r_s3_un [4];
    logic [31:0]              r_s3_ud [2];
    logic                     r_s3_ok;
    logic [31:0]              r_s3_color;
    logic [31:0]              n_s3_un [4];
    logic [31:0]              n_s3_ud [2];
    t_sdiv                    r_sd [NSD+1];
    t_sdiv                    n_sd0;
    t_sdiv                    n_sd [1:NSD];
    t_out_item                r_out_data;
    t_out_item                n_out_data;

    // Pipeline advances unless a result waits unaccepted
    assign w_adv       = ~r_sv[NSV-1] | i_out_ready;
    assign o_in_ready  = w_adv;
    assign o_cfg_ready = 1'b1;

    // Matrix registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 4; c++) begin
                    r_mat[r][c] <= '0;
                end
            end
        end else if (i_cfg_valid) begin
            r_mat[i_cfg_index[2:1]][{i_cfg_index[0], 1'b0}] <= i_cfg_data[31:0];
            r_mat[i_cfg_index[2:1]][{i_cfg_index[0], 1'b1}] <= i_cfg_data[63:32];
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_vld <= '0;
            r_sv    <= '0;
        end else if (w_adv) begin
            r_t_vld <= {r_t_vld[1:0], i_in_valid};
            r_sv    <= {r_sv[NSV-2:0], w_pl_vld[NUM_PLANES]};
        end
    end

    // Endpoint coordinates
    always_comb begin
        w_pt[0][0] = i_in_data.start_x;
        w_pt[0][1] = i_in_data.start_y;
        w_pt[0][2] = i_in_data.start_z;
        w_pt[1][0] = i_in_data.end_x;
        w_pt[1][1] = i_in_data.end_y;
        w_pt[1][2] = i_in_data.end_z;
    end

    // Transform: full sum, floor to the coordinate format, range check
    always_comb begin
        logic signed [65:0] s;
        logic signed [65:0] sh;
        n_t3_seg       = '0;
        n_t3_seg.ok    = 1'b1;
        n_t3_seg.color = r_t2_color;
        for (int e = 0; e < 2; e++) begin
            for (int r = 0; r < 4; r++) begin
                s  = 66'(r_ps0[e][r]) + 66'(r_ps1[e][r]);
                sh = s >>> COORD_FRAC_BITS;
                if (sh >= CLIP_LIM || sh <= -CLIP_LIM) begin
                    n_t3_seg.ok = 1'b0;
                end
                if (e == 0) begin
                    n_t3_seg.a[r] = sh[CLIP_W-1:0];
                end else begin
                    n_t3_seg.b[r] = sh[CLIP_W-1:0];
                end
            end
        end
    end

    // Clip plane chain
    assign w_pl_vld[0] = r_t_vld[2];
    assign w_pl_seg[0] = r_t3_seg;

    for (genvar k = 0; k < NUM_PLANES; k++) begin : g_plane
        cslp_clip_plane #(
            .PLANE (t_plane'(k))
        ) u_plane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_vld   (w_pl_vld[k]),
            .i_seg   (w_pl_seg[k]),
            .o_vld   (w_pl_vld[k+1]),
            .o_seg   (w_pl_seg[k+1])
        );
    end

    // Viewport stage 1: w check, numerators c+w and denominators 2w
    always_comb begin
        t_seg seg;
        seg     = w_pl_seg[NUM_PLANES];
        n_s1_ok = seg.ok & ($signed(seg.a[3]) > 0) & ($signed(seg.b[3]) > 0);
        n_s1_den[0] = DIST_W'($signed(seg.a[3])) <<< 1;
        n_s1_den[1] = DIST_W'($signed(seg.b[3])) <<< 1;
        for (int l = 0; l < 2; l++) begin
            n_s1_num[l]   = DIST_W'($signed(seg.a[l])) + DIST_W'($signed(seg.a[3]));
            n_s1_num[l+2] = DIST_W'($signed(seg.b[l])) + DIST_W'($signed(seg.b[3]));
        end
    end

    // Viewport stage 3: scale so the denominator fits in 32 bits
    always_comb begin
        logic [4:0] sh;
        for (int e = 0; e < 2; e++) begin
            sh = '0;
            for (int j = 0; j < DIST_W - 32; j++) begin
                if (r_s2_ud[e][32+j]) begin
                    sh = 5'(j + 1);
                end
            end
            n_s3_ud[e] = 32'(r_s2_ud[e] >> sh);
            for (int c = 0; c < 2; c++) begin
                n_s3_un[2*e+c] = 32'(r_s2_un[2*e+c] >> sh);
            end
        end
    end

    // Viewport stage 4: rounded numerator, split into divider start state
    always_comb begin
        logic [NW-1:0] nv;
        n_sd0 = '0;
        for (int l = 0; l < 4; l++) begin
            nv = (NW'(r_s3_un[l]) << SCREEN_FRAC_BITS) + NW'(r_s3_ud[l/2] >> 1);
            n_sd0.rem[l]  = nv[NW-1:QS];
            n_sd0.feed[l] = nv[QS-1:0];
        end
        n_sd0.d     = {r_s3_ud[1], r_s3_ud[0]};
        n_sd0.ok    = r_s3_ok;
        n_sd0.color = r_s3_color;
    end

    // Viewport divider stages
    always_comb begin
        logic [32:0] st;
        for (int s = 0; s < NSD; s++) begin
            n_sd[s+1] = r_sd[s];
            for (int j = 0; j < DIV_STEPS; j++) begin
                if (s * DIV_STEPS + j < QS) begin
                    for (int l = 0; l < 4; l++) begin
                        st = div_step(n_sd[s+1].rem[l], n_sd[s+1].feed[l][QS-1],
                                      n_sd[s+1].d[l/2]);
                        n_sd[s+1].rem[l]  = st[31:0];
                        n_sd[s+1].q[l]    = {n_sd[s+1].q[l][QS-2:0], st[32]};
                        n_sd[s+1].feed[l] = {n_sd[s+1].feed[l][QS-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // Result formatting; rejected segments come out all zero
    always_comb begin
        n_out_data = '0;
        if (r_sd[NSD].ok) begin
            n_out_data.visible        = 1'b1;
            n_out_data.screen_start_x = 17'(r_sd[NSD].q[0]);
            n_out_data.screen_start_y = 17'(r_sd[NSD].q[1]);
            n_out_data.screen_end_x   = 17'(r_sd[NSD].q[2]);
            n_out_data.screen_end_y   = 17'(r_sd[NSD].q[3]);
            n_out_data.out_color      = r_sd[NSD].color;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // transform: products, pair sums, final sum
            for (int e = 0; e < 2; e++) begin
                for (int r = 0; r < 4; r++) begin
                    for (int c = 0; c < 3; c++) begin
                        r_prod[e][r][c] <= r_mat[r][c] * w_pt[e][c];
                    end
                    r_ps0[e][r] <= 65'(r_prod[e][r][0]) + 65'(r_prod[e][r][1]);
                    r_ps1[e][r] <= 65'(r_prod[e][r][2])
                                 + (65'(r_mat[r][3]) <<< COORD_FRAC_BITS);
                end
            end
            r_t1_color <= i_in_data.line_color;
            r_t2_color <= r_t1_color;
            r_t3_seg   <= n_t3_seg;

            // viewport mapping
            r_s1_num   <= n_s1_num;
            r_s1_den   <= n_s1_den;
            r_s1_ok    <= n_s1_ok;
            r_s1_color <= w_pl_seg[NUM_PLANES].color;
            for (int l = 0; l < 4; l++) begin
                if (r_s1_num[l] < 0) begin
                    r_s2_un[l] <= '0;
                end else if (r_s1_num[l] > r_s1_den[l/2]) begin
                    r_s2_un[l] <= r_s1_den[l/2];
                end else begin
                    r_s2_un[l] <= r_s1_num[l];
                end
            end
            for (int e = 0; e < 2; e++) begin
                r_s2_ud[e] <= $unsigned(r_s1_den[e]);
            end
            r_s2_ok    <= r_s1_ok;
            r_s2_color <= r_s1_color;
            r_s3_un    <= n_s3_un;
            r_s3_ud    <= n_s3_ud;
            r_s3_ok    <= r_s2_ok;
            r_s3_color <= r_s2_color;
            r_sd[0]    <= n_sd0;
            for (int s = 1; s <= NSD; s++) begin
                r_sd[s] <= n_sd[s];
            end
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_sv[NSV-1];
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire
